// ===== design/tnsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnsr_pkg
// Field widths, stream packing widths and controller/datapath interface types
// for the top-N score table.
// ----------------------------------------------------------------------------
package tnsr_pkg;

    localparam int SCORE_W   = 31;
    localparam int TAG_W     = 16;
    localparam int SLOT_W    = 5;
    localparam int RANK_W    = 6;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;

    typedef logic [SCORE_W-1:0] score_t;
    typedef logic [TAG_W-1:0]   tag_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [RANK_W-1:0]  rank_t;

    typedef struct packed {
        logic load;     // input transfer: insert new entry, restart readout
        logic advance;  // output transfer: step to next slot
    } cmd_t;

    typedef struct packed {
        logic last;     // readout is on the bottom slot
    } status_t;

endpackage

// ===== design/tnsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnsr_ctrl
// Controller: alternates between waiting for an entry and streaming the table.
// ----------------------------------------------------------------------------
module tnsr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tnsr_pkg::status_t status,
    output tnsr_pkg::cmd_t    cmd
);
    import tnsr_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_STREAM = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = (state_reg == ST_STREAM);
    assign cmd.load    = s_tvalid && s_tready;
    assign cmd.advance = m_tvalid && m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM: begin
                if (cmd.advance && status.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/tnsr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnsr_dp
// Datapath: sorted score/tag table with stable insertion, readout
// slot counter and running competition rank.
// ----------------------------------------------------------------------------
module tnsr_dp #(
    parameter int ENTRIES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tnsr_pkg::cmd_t    cmd,
    input  tnsr_pkg::score_t  new_score,
    input  tnsr_pkg::tag_t    new_tag,
    output tnsr_pkg::status_t status,
    output tnsr_pkg::slot_t   slot,
    output tnsr_pkg::rank_t   entry_rank,
    output tnsr_pkg::score_t  entry_score,
    output tnsr_pkg::tag_t    entry_tag
);
    import tnsr_pkg::*;

    localparam int CW = $clog2(ENTRIES);

    score_t         score_reg [ENTRIES];
    tag_t           tag_reg   [ENTRIES];
    score_t         score_next[ENTRIES];
    tag_t           tag_next  [ENTRIES];
    logic [ENTRIES-1:0] ge;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_inc;
    rank_t          rank_reg;

    // table is kept sorted; ge is a run of ones from the top
    always_comb begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
            ge[i] = (score_reg[i] >= new_score);
        end
        ge[ENTRIES-1] = 1'b0;  // bottom slot is always replaced
        score_next[0] = ge[0] ? score_reg[0] : new_score;
        tag_next[0]   = ge[0] ? tag_reg[0]   : new_tag;
        for (int i = 1; i < ENTRIES; i++) begin
            if (ge[i]) begin
                score_next[i] = score_reg[i];
                tag_next[i]   = tag_reg[i];
            end else if (ge[i-1]) begin
                score_next[i] = new_score;
                tag_next[i]   = new_tag;
            end else begin
                score_next[i] = score_reg[i-1];
                tag_next[i]   = tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                score_reg[i] <= '0;
                tag_reg[i]   <= '0;
            end
        end else if (cmd.load) begin
            for (int i = 0; i < ENTRIES; i++) begin
                score_reg[i] <= score_next[i];
                tag_reg[i]   <= tag_next[i];
            end
        end
    end

    assign cnt_inc     = cnt_reg + 1'b1;
    assign status.last = (cnt_reg == CW'(ENTRIES - 1));

    // equal score shares the rank above, otherwise rank is position plus one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            rank_reg <= RANK_W'(1);
        end else if (cmd.load) begin
            cnt_reg  <= '0;
            rank_reg <= RANK_W'(1);
        end else if (cmd.advance && !status.last) begin
            cnt_reg <= cnt_inc;
            if (score_reg[cnt_inc] != score_reg[cnt_reg]) begin
                rank_reg <= RANK_W'(cnt_reg) + RANK_W'(2);
            end
        end
    end

    assign slot        = SLOT_W'(cnt_reg);
    assign entry_rank  = rank_reg;
    assign entry_score = score_reg[cnt_reg];
    assign entry_tag   = tag_reg[cnt_reg];

endmodule

// ===== design/top_n_score_table_with_rank_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_n_score_table_with_rank_top
// Top-N score table, sorted by descending score, with competition ranking.
// Latency: first result is valid the cycle after the input transfer.
// Throughput: each entry is inserted, then with no output stall the table
// readout mux gives one result per cycle.
// Reset: synchronous active-low aresetn clears the table to all zero.
// ----------------------------------------------------------------------------
module top_n_score_table_with_rank_top #(
    parameter int ENTRIES = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tnsr_pkg::S_TDATA_W-1:0]    s_tdata,  // new_score, new_tag
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tnsr_pkg::M_TDATA_W-1:0]    m_tdata,  // slot, entry_rank,
                                                         // entry_score, entry_tag
    output logic                              m_tlast
);
    import tnsr_pkg::*;

    cmd_t    cmd;
    status_t status;
    slot_t   slot;
    rank_t   entry_rank;
    score_t  entry_score;
    tag_t    entry_tag;

    tnsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tnsr_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .new_score   (s_tdata[SCORE_W-1:0]),
        .new_tag     (s_tdata[SCORE_W+TAG_W-1:SCORE_W]),
        .status      (status),
        .slot        (slot),
        .entry_rank  (entry_rank),
        .entry_score (entry_score),
        .entry_tag   (entry_tag)
    );

    assign m_tdata = {{(M_TDATA_W-SLOT_W-RANK_W-SCORE_W-TAG_W){1'b0}},
                      entry_tag, entry_score, entry_rank, slot};
    assign m_tlast = status.last;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while streaming");

    a_first_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid && (slot == '0) && (entry_rank == RANK_W'(1)))
        else $error("readout did not restart at top slot");

    a_end_of_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("not idle after last transfer");

    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (entry_rank <= ({1'b0, slot} + RANK_W'(1))))
        else $error("rank exceeds position");

endmodule
